// ----- rtl/core/epf_pkg.sv -----
// ----------------------------------------------------------------------------
// epf_pkg
// Shared types and constants of the eased waypoint path follower
// ----------------------------------------------------------------------------
`default_nettype none

package epf_pkg;

    // geometry of the waypoint table
    localparam int MAX_POINTS  = 16;
    localparam int PT_IDX_BITS = 4;
    localparam int COORD_BITS  = 12;

    // fixed-point constants
    localparam logic [33:0] Q_ONE     = 34'h0_0001_0000;
    localparam logic [32:0] INC_LIMIT = 33'h1_0000_0000;
    localparam logic [19:0] US_PER_S  = 20'd1000000;

    // iteration counts of the shared loops
    localparam logic [5:0] SQ_STEPS  = 6'd21;
    localparam logic [5:0] DIV_STEPS = 6'd60;

    // configuration register indexes
    localparam logic [1:0] REG_SPEED  = 2'd0;
    localparam logic [1:0] REG_SMOOTH = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    // request kinds
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_RESET = 2'd3
    } func_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [15:0] speed;
        logic [16:0] smooth;
        logic [4:0]  count;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rd_a;
        logic rd_b;
        logic lat_a;
        logic lat_b;
        logic sq_x;
        logic sq_y;
        logic sq_init;
        logic sq_step;
        logic mul;
        logic div_init;
        logic div_step;
        logic inc_zero;
        logic inc_cap;
        logic prog_add;
        logic carry_fin;
        logic carry_next;
        logic zero_fix;
        logic ease1;
        logic ease2;
        logic ease3;
        logic ease4;
        logic ease5;
        logic ease6;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        func_t func;
        logic  tick_ok;
        logic  d2_zero;
        logic  prog_ovf;
        logic  at_last;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/eased_waypoint_path_follower.sv -----
// ----------------------------------------------------------------------------
// eased_waypoint_path_follower
// Moves a target along a table of waypoints with blended smoothstep easing
// ----------------------------------------------------------------------------
//  channel   dir  ports                      content
//  s_        in   tvalid tready tdata tuser  load, start, tick or reset request
//  m_        out  tvalid tready tdata        eased position and run flags
//  apb       in   psel penable pwrite ...    speed, smoothness, point count
//
//  A load, start or reset request reads the segment endpoints, runs the
//  easing steps and loads the result. A tick also runs the 21-step root and
//  the 60-step divider and carries over each segment boundary crossed; a
//  tick on a zero-length segment skips both loops.
//  One request is worked at a time; the next is accepted while a result
//  still waits on m_tready. Reset is synchronous, active low; the waypoint
//  table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_waypoint_path_follower (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // point_index, point_x, point_y, tick_delta_us
    input  wire logic [1:0]  s_tuser,   // func
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // pos_x, pos_y, run_state, finished
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    epf_pkg::cfg_t cfg;
    epf_pkg::cmd_t cmd;
    epf_pkg::sts_t sts;

    epf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    epf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    epf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/epf_regs.sv -----
// ----------------------------------------------------------------------------
// epf_regs
// Configuration registers behind a simple peripheral bus port
// ----------------------------------------------------------------------------
`default_nettype none

module epf_regs (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output epf_pkg::cfg_t       cfg
);

    logic [15:0] speed_reg, speed_next;
    logic [16:0] smooth_reg, smooth_next;
    logic [4:0]  count_reg, count_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // write decode with clamping
    always_comb begin
        speed_next  = speed_reg;
        smooth_next = smooth_reg;
        count_next  = count_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                epf_pkg::REG_SPEED: begin
                    speed_next = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
                end
                epf_pkg::REG_SMOOTH: begin
                    smooth_next = (pwdata[16:0] > 17'h10000) ? 17'h10000 : pwdata[16:0];
                end
                epf_pkg::REG_COUNT: begin
                    count_next = pwdata[4:0];
                end
                default: begin
                    speed_next = speed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= 16'd100;
            smooth_reg <= 17'd0;
            count_reg  <= 5'd2;
        end else begin
            speed_reg  <= speed_next;
            smooth_reg <= smooth_next;
            count_reg  <= count_next;
        end
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            epf_pkg::REG_SPEED:  prdata = {16'd0, speed_reg};
            epf_pkg::REG_SMOOTH: prdata = {15'd0, smooth_reg};
            epf_pkg::REG_COUNT:  prdata = {27'd0, count_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.speed  = speed_reg;
    assign cfg.smooth = smooth_reg;
    assign cfg.count  = count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/epf_dp.sv -----
// ----------------------------------------------------------------------------
// epf_dp
// Datapath: waypoint memory, path state, square root, divider, easing
// ----------------------------------------------------------------------------
`default_nettype none

module epf_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire epf_pkg::cmd_t  cmd,
    output epf_pkg::sts_t       sts,
    input  wire epf_pkg::cfg_t  cfg,
    input  wire logic [47:0]    s_tdata,
    input  wire logic [1:0]     s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [31:0]    m_tdata
);

    // waypoint memory, x in low bits, y in high bits
    logic [23:0] wp_mem [epf_pkg::MAX_POINTS];
    logic [23:0] rd_q_reg;
    logic [3:0]  rd_addr;

    // request fields
    epf_pkg::func_t func_in, func_reg;
    logic [3:0]  in_idx;
    logic [11:0] in_x, in_y;
    logic [19:0] in_delta, delta_reg;

    // path state
    logic [3:0]  seg_reg, seg_next;
    logic [33:0] prog_reg, prog_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [3:0]  seg_b;
    logic [4:0]  n_pts;
    logic [3:0]  last_seg;

    // segment endpoints
    logic [11:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [12:0] diff_x, diff_y, dmul;
    logic signed [25:0] sq;
    logic [25:0] d2_reg;

    // square root
    logic [41:0] v_reg, r_reg, bit_reg;
    logic [42:0] sq_sum;
    logic        sq_ge;

    // divider
    logic [35:0] num_reg, num_w, nsh_reg;
    logic [40:0] den_reg, den_w;
    logic [40:0] rem_reg;
    logic [41:0] rem_sh;
    logic        div_ge;
    logic [32:0] q_reg, inc_reg;
    logic        ovf_reg;

    // easing
    logic [16:0] t_clamp, t_reg, sm_reg, e_reg;
    logic [33:0] tt_reg, tt_w;
    logic [17:0] fac;
    logic [51:0] sm_prod;
    logic [17:0] one_minus_s;
    logic [34:0] p1_reg, p1_w, esum;
    logic [33:0] sms;
    logic signed [30:0] pmul, px_reg, py_reg;

    // output register
    logic        mv_reg, mv_next;
    logic [31:0] md_reg;

    function automatic logic [11:0] apply_off(logic [11:0] a, logic signed [30:0] p);
        logic [30:0] mag;
        logic [11:0] sh;
        mag = p[30] ? 31'(-p) : 31'(p);
        sh  = mag[27:16];
        return p[30] ? (a - sh) : (a + sh);
    endfunction

    assign func_in  = epf_pkg::func_t'(s_tuser);
    assign in_idx   = s_tdata[3:0];
    assign in_x     = s_tdata[15:4];
    assign in_y     = s_tdata[27:16];
    assign in_delta = s_tdata[47:28];

    // clamp of the point count, last usable segment
    assign n_pts    = (cfg.count < 5'd2) ? 5'd2 :
                      (cfg.count > 5'(epf_pkg::MAX_POINTS)) ? 5'(epf_pkg::MAX_POINTS) :
                      cfg.count;
    assign last_seg = 4'(n_pts - 5'd2);
    assign seg_b    = (seg_reg == 4'(epf_pkg::MAX_POINTS - 1)) ? seg_reg : seg_reg + 4'd1;

    // memory write and registered read
    assign rd_addr = cmd.rd_b ? seg_b : seg_reg;
    always_ff @(posedge aclk) begin
        if (cmd.accept && func_in == epf_pkg::FUNC_LOAD) begin
            wp_mem[in_idx] <= {in_y, in_x};
        end
        rd_q_reg <= wp_mem[rd_addr];
    end

    // shared coordinate difference multiplier
    assign diff_x = $signed({1'b0, bx_reg}) - $signed({1'b0, ax_reg});
    assign diff_y = $signed({1'b0, by_reg}) - $signed({1'b0, ay_reg});
    assign dmul   = (cmd.sq_y || cmd.ease6) ? diff_y : diff_x;
    assign sq     = dmul * dmul;
    assign pmul   = dmul * $signed({1'b0, e_reg});

    // square root step
    assign sq_sum = {1'b0, r_reg} + {1'b0, bit_reg};
    assign sq_ge  = {1'b0, v_reg} >= sq_sum;

    // divider step
    assign num_w  = 36'(delta_reg) * 36'(cfg.speed);
    assign den_w  = 41'(r_reg[20:0]) * 41'(epf_pkg::US_PER_S);
    assign rem_sh = {rem_reg, nsh_reg[35]};
    assign div_ge = rem_sh >= {1'b0, den_reg};

    // easing products
    assign t_clamp     = (prog_reg > epf_pkg::Q_ONE) ? 17'h10000 : prog_reg[16:0];
    assign tt_w        = 34'(t_reg) * 34'(t_reg);
    assign fac         = 18'd196608 - {t_reg, 1'b0};
    assign sm_prod     = 52'(tt_reg) * 52'(fac);
    assign one_minus_s = 18'h10000 - {1'b0, cfg.smooth};
    assign p1_w        = 35'(t_reg) * 35'(one_minus_s);
    assign sms         = 34'(sm_reg) * 34'(cfg.smooth);
    assign esum        = p1_reg + 35'(sms);

    // path state update
    always_comb begin
        seg_next  = seg_reg;
        prog_next = prog_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (cmd.accept) begin
            unique case (func_in)
                epf_pkg::FUNC_LOAD: begin
                    seg_next = seg_reg;
                end
                epf_pkg::FUNC_START: begin
                    if (!run_reg) begin
                        run_next  = 1'b1;
                        seg_next  = 4'd0;
                        prog_next = 34'd0;
                        done_next = 1'b0;
                    end
                end
                epf_pkg::FUNC_TICK: begin
                    seg_next = seg_reg;
                end
                epf_pkg::FUNC_RESET: begin
                    run_next  = 1'b0;
                    seg_next  = 4'd0;
                    prog_next = 34'd0;
                    done_next = 1'b0;
                end
                default: begin
                    seg_next = seg_reg;
                end
            endcase
        end
        if (cmd.prog_add) begin
            prog_next = prog_reg + {1'b0, inc_reg};
        end
        if (cmd.carry_fin) begin
            seg_next  = last_seg;
            prog_next = epf_pkg::Q_ONE;
            done_next = 1'b1;
        end
        if (cmd.carry_next) begin
            seg_next  = seg_reg + 4'd1;
            prog_next = prog_reg - epf_pkg::Q_ONE;
        end
        if (cmd.zero_fix && ax_reg == bx_reg && ay_reg == by_reg) begin
            prog_next = epf_pkg::Q_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg  <= 4'd0;
            prog_reg <= 34'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            func_reg <= epf_pkg::FUNC_LOAD;
        end else begin
            seg_reg  <= seg_next;
            prog_reg <= prog_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            if (cmd.accept) begin
                func_reg <= func_in;
            end
        end
    end

    // working registers of the arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            delta_reg <= in_delta;
        end
        if (cmd.lat_a) begin
            ax_reg <= rd_q_reg[11:0];
            ay_reg <= rd_q_reg[23:12];
        end
        if (cmd.lat_b) begin
            bx_reg <= rd_q_reg[11:0];
            by_reg <= rd_q_reg[23:12];
        end
        if (cmd.sq_x) begin
            d2_reg <= {2'b00, sq[23:0]};
        end
        if (cmd.sq_y) begin
            d2_reg <= d2_reg + {2'b00, sq[23:0]};
        end
        if (cmd.sq_init) begin
            v_reg   <= {d2_reg, 16'd0};
            r_reg   <= 42'd0;
            bit_reg <= 42'd1 << 40;
        end
        if (cmd.sq_step) begin
            if (sq_ge) begin
                v_reg <= v_reg - sq_sum[41:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mul) begin
            num_reg <= num_w;
        end
        if (cmd.div_init) begin
            den_reg <= den_w;
            nsh_reg <= num_reg;
            rem_reg <= 41'd0;
            q_reg   <= 33'd0;
            ovf_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            rem_reg <= div_ge ? 41'(rem_sh - {1'b0, den_reg}) : rem_sh[40:0];
            q_reg   <= {q_reg[31:0], div_ge};
            ovf_reg <= ovf_reg | q_reg[32];
            nsh_reg <= nsh_reg << 1;
        end
        if (cmd.inc_zero) begin
            inc_reg <= 33'(epf_pkg::Q_ONE);
        end
        if (cmd.inc_cap) begin
            inc_reg <= (ovf_reg || (q_reg[32] && |q_reg[31:0])) ? epf_pkg::INC_LIMIT : q_reg;
        end
        if (cmd.ease1) begin
            t_reg <= t_clamp;
        end
        if (cmd.ease2) begin
            tt_reg <= tt_w;
        end
        if (cmd.ease3) begin
            sm_reg <= sm_prod[48:32];
            p1_reg <= p1_w;
        end
        if (cmd.ease4) begin
            e_reg <= esum[32:16];
        end
        if (cmd.ease5) begin
            px_reg <= pmul;
        end
        if (cmd.ease6) begin
            py_reg <= pmul;
        end
    end

    // result register
    always_comb begin
        mv_next = mv_reg;
        if (m_tready) begin
            mv_next = 1'b0;
        end
        if (cmd.out_load) begin
            mv_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else begin
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            md_reg <= {6'd0, done_reg, run_reg,
                       apply_off(ay_reg, py_reg), apply_off(ax_reg, px_reg)};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // status
    assign sts.func     = func_reg;
    assign sts.tick_ok  = run_reg && !done_reg;
    assign sts.d2_zero  = (d2_reg == 26'd0);
    assign sts.prog_ovf = |prog_reg[33:16];
    assign sts.at_last  = (seg_reg >= last_seg);
    assign sts.out_free = !mv_reg || m_tready;

endmodule

`default_nettype wire

// ----- rtl/core/epf_ctrl.sv -----
// ----------------------------------------------------------------------------
// epf_ctrl
// Controller: sequences reads, root, division, carry and easing steps
// ----------------------------------------------------------------------------
`default_nettype none

module epf_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output epf_pkg::cmd_t       cmd,
    input  wire epf_pkg::sts_t  sts
);

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_DISP = 24'h000002,
        S_RA   = 24'h000004,
        S_RB   = 24'h000008,
        S_LB   = 24'h000010,
        S_SQX  = 24'h000020,
        S_SQY  = 24'h000040,
        S_SQI  = 24'h000080,
        S_SQS  = 24'h000100,
        S_MUL  = 24'h000200,
        S_DVI  = 24'h000400,
        S_DVS  = 24'h000800,
        S_CAP  = 24'h001000,
        S_ADD  = 24'h002000,
        S_CHK  = 24'h004000,
        S_ZFX  = 24'h008000,
        S_E1   = 24'h010000,
        S_E2   = 24'h020000,
        S_E3   = 24'h040000,
        S_E4   = 24'h080000,
        S_E5   = 24'h100000,
        S_E6   = 24'h200000,
        S_OUT  = 24'h400000,
        S_SPR  = 24'h800000
    } state_t;

    // purpose of the current endpoint read
    typedef enum logic [2:0] {
        CTX_TICK  = 3'b001,
        CTX_CARRY = 3'b010,
        CTX_OUT   = 3'b100
    } ctx_t;

    state_t     state_reg, state_next;
    ctx_t       ctx_reg, ctx_next;
    logic [5:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                ctx_next   = (sts.func == epf_pkg::FUNC_TICK && sts.tick_ok) ? CTX_TICK
                                                                             : CTX_OUT;
                state_next = S_RA;
            end
            S_RA: begin
                cmd.rd_a   = 1'b1;
                state_next = S_RB;
            end
            S_RB: begin
                cmd.rd_b   = 1'b1;
                cmd.lat_a  = 1'b1;
                state_next = S_LB;
            end
            S_LB: begin
                cmd.lat_b = 1'b1;
                unique case (ctx_reg)
                    CTX_TICK:  state_next = S_SQX;
                    CTX_CARRY: state_next = S_ZFX;
                    CTX_OUT:   state_next = S_E1;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = S_SQI;
            end
            S_SQI: begin
                if (sts.d2_zero) begin
                    cmd.inc_zero = 1'b1;
                    state_next   = S_ADD;
                end else begin
                    cmd.sq_init = 1'b1;
                    cnt_next    = epf_pkg::SQ_STEPS - 6'd1;
                    state_next  = S_SQS;
                end
            end
            S_SQS: begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DVI;
            end
            S_DVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = epf_pkg::DIV_STEPS - 6'd1;
                state_next   = S_DVS;
            end
            S_DVS: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                cmd.inc_cap = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD: begin
                cmd.prog_add = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK: begin
                state_next = S_RA;
                priority if (!sts.prog_ovf) begin
                    ctx_next = CTX_OUT;
                end else if (sts.at_last) begin
                    cmd.carry_fin = 1'b1;
                    ctx_next      = CTX_OUT;
                end else begin
                    cmd.carry_next = 1'b1;
                    ctx_next       = CTX_CARRY;
                end
            end
            S_ZFX: begin
                cmd.zero_fix = 1'b1;
                state_next   = S_CHK;
            end
            S_E1: begin
                cmd.ease1  = 1'b1;
                state_next = S_E2;
            end
            S_E2: begin
                cmd.ease2  = 1'b1;
                state_next = S_E3;
            end
            S_E3: begin
                cmd.ease3  = 1'b1;
                state_next = S_E4;
            end
            S_E4: begin
                cmd.ease4  = 1'b1;
                state_next = S_E5;
            end
            S_E5: begin
                cmd.ease5  = 1'b1;
                state_next = S_E6;
            end
            S_E6: begin
                cmd.ease6  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctx_reg   <= CTX_OUT;
            cnt_reg   <= 6'd0;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/epf_checker.sv -----
// ----------------------------------------------------------------------------
// epf_checker
// Port-level checks of the path follower, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module epf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        pready
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> (m_tdata === $past(m_tdata)))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // the path only finishes while running
    a_done_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> m_tdata[24])
        else $error("finished reported on the start screen");

    // configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port stalled");

endmodule

bind eased_waypoint_path_follower epf_checker u_epf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream and register level test of the eased waypoint path follower: a
// clocked driver sends load, start, tick and reset requests from a queue, a
// built-in path predictor computes each eased position, and a clocked
// monitor compares every result with the oldest prediction while both sides
// idle at random across several configuration phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        epf_pkg::func_t func;
        logic [3:0]     idx;
        logic [11:0]    px;
        logic [11:0]    py;
        logic [19:0]    dt;
    } path_req_t;

    typedef struct {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        run;
        logic        fin;
        logic        pos_known;
    } path_pos_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // point_index, point_x, point_y, tick_delta_us
    logic [1:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pos_x, pos_y, run_state, finished
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    eased_waypoint_path_follower dut (.*);

    // requests waiting for the driver and positions waiting for the monitor
    path_req_t pending_reqs[$];
    path_pos_t expected_pos[$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned mismatches;
    int unsigned idle_cycles;

    // predictor state
    logic [11:0]     wp_x[16];
    logic [11:0]     wp_y[16];
    logic            wp_written[16];
    int unsigned     cfg_speed;
    int unsigned     cfg_smooth;
    int unsigned     cfg_count;
    int unsigned     seg;
    longint unsigned prog;
    logic            running;
    logic            done;

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int unsigned slot_of(int unsigned i);
        return (i < epf_pkg::MAX_POINTS) ? i : epf_pkg::MAX_POINTS - 1;
    endfunction

    function automatic int unsigned used_count();
        if (cfg_count < 2) return 2;
        if (cfg_count > epf_pkg::MAX_POINTS) return epf_pkg::MAX_POINTS;
        return cfg_count;
    endfunction

    // Q8 segment length by integer square root
    function automatic longint unsigned seg_len(int unsigned i);
        longint signed   dx, dy;
        longint unsigned v, r, bitv;
        dx = longint'(wp_x[slot_of(i + 1)]) - longint'(wp_x[slot_of(i)]);
        dy = longint'(wp_y[slot_of(i + 1)]) - longint'(wp_y[slot_of(i)]);
        v = longint'(dx * dx + dy * dy) << 16;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned ease_of(longint unsigned t);
        longint unsigned sm;
        sm = (t * t * (196608 - 2 * t)) >> 32;
        return (t * (65536 - cfg_smooth) + sm * cfg_smooth) >> 16;
    endfunction

    function automatic logic [11:0] lerp(logic [11:0] a, logic [11:0] b,
                                         longint unsigned e);
        longint signed p, off;
        p = (longint'(b) - longint'(a)) * longint'(e);
        off = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
        return 12'(longint'(a) + off);
    endfunction

    // move along the path by one tick
    function automatic void advance(logic [19:0] dt);
        int unsigned     last;
        longint unsigned len, inc;
        last = used_count() - 2;
        len = seg_len(seg);
        if (done || !running) return;
        if (len == 0) begin
            inc = 65536;
        end else begin
            inc = ((longint'(dt) * cfg_speed) << 24) / (len * 1000000);
            if (inc > (64'd1 << 32)) inc = 64'd1 << 32;
        end
        prog += inc;
        for (int g = 0; g <= epf_pkg::MAX_POINTS && prog >= 65536; g++) begin
            if (seg >= last) begin
                seg = last;
                prog = 65536;
                done = 1'b1;
                break;
            end
            prog -= 65536;
            seg++;
            if (seg_len(seg) == 0) prog = 65536;
        end
    endfunction

    function automatic path_pos_t predict_pos(path_req_t r);
        path_pos_t       o;
        int unsigned     a, b;
        longint unsigned e;
        case (r.func)
            epf_pkg::FUNC_LOAD: begin
                wp_x[r.idx] = r.px;
                wp_y[r.idx] = r.py;
                wp_written[r.idx] = 1'b1;
            end
            epf_pkg::FUNC_START: begin
                if (!running) begin
                    running = 1'b1;
                    seg = 0;
                    prog = 0;
                    done = 1'b0;
                end
            end
            epf_pkg::FUNC_TICK: advance(r.dt);
            default: begin
                seg = 0;
                prog = 0;
                done = 1'b0;
                running = 1'b0;
            end
        endcase
        e = ease_of(prog > 65536 ? 65536 : prog);
        a = slot_of(seg);
        b = slot_of(seg + 1);
        o.pos_x = lerp(wp_x[a], wp_x[b], e);
        o.pos_y = lerp(wp_y[a], wp_y[b], e);
        o.run = running;
        o.fin = done;
        o.pos_known = wp_written[a] && wp_written[b];
        return o;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pos.insert(expected_pos.size(),
                                    predict_pos(pending_reqs.pop_front()));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_reqs[0].func;
                    s_tdata  <= {pending_reqs[0].dt, pending_reqs[0].py,
                                 pending_reqs[0].px, pending_reqs[0].idx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        path_pos_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_pos.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    w = expected_pos.pop_front();
                    if ((w.pos_known && (m_tdata[11:0] !== w.pos_x
                                         || m_tdata[23:12] !== w.pos_y))
                        || m_tdata[24] !== w.run || m_tdata[25] !== w.fin) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected x %0d y %0d run %0d fin %0d, got x %0d y %0d run %0d fin %0d",
                                     w.pos_x, w.pos_y, w.run, w.fin, m_tdata[11:0],
                                     m_tdata[23:12], m_tdata[24], m_tdata[25]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            epf_pkg::REG_SPEED:  cfg_speed = (value[15:0] == 0) ? 1 : value[15:0];
            epf_pkg::REG_SMOOTH: cfg_smooth = (value[16:0] > 65536) ? 65536 : value[16:0];
            default:             cfg_count = value[4:0];
        endcase
    endtask

    task automatic push_req(epf_pkg::func_t f, int unsigned idx, int unsigned x,
                            int unsigned y, int unsigned dt);
        path_req_t r;
        r.func = f;
        r.idx = 4'(idx);
        r.px = 12'(x);
        r.py = 12'(y);
        r.dt = 20'(dt);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic int unsigned pick_coord();
        case ($urandom_range(3))
            0:       return ($urandom_range(1) ? 4095 : 0);
            1:       return $urandom_range(2000, 2100);
            default: return $urandom_range(4095);
        endcase
    endfunction

    // mostly ticks on a running path, with loads, restarts and resets mixed in
    task automatic push_random_req();
        int unsigned k;
        int unsigned dt;
        k = $urandom_range(99);
        case ($urandom_range(3))
            0:       dt = $urandom_range(1048575);
            1:       dt = $urandom_range(1000);
            default: dt = $urandom_range(200000);
        endcase
        if (k < 12) push_req(epf_pkg::FUNC_LOAD, $urandom_range(15), pick_coord(),
                             pick_coord(), dt);
        else if (k < 22) push_req(epf_pkg::FUNC_START, $urandom_range(15),
                                  $urandom_range(4095), $urandom_range(4095), dt);
        else if (k < 27) push_req(epf_pkg::FUNC_RESET, $urandom_range(15),
                                  $urandom_range(4095), $urandom_range(4095), dt);
        else push_req(epf_pkg::FUNC_TICK, $urandom_range(15), $urandom_range(4095),
                      $urandom_range(4095), dt);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_pos.size() > 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned speeds[8]  = '{0, 65535, 100, 1, 3000, 20000, 65535, 500};
        int unsigned smooths[8] = '{0, 65536, 70000, 32768, 131071, 0, 65536, 12345};
        int unsigned counts[8]  = '{16, 2, 31, 0, 1, 9, 16, 5};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = epf_pkg::FUNC_LOAD;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        cfg_speed = 100;
        cfg_smooth = 0;
        cfg_count = 2;
        seg = 0;
        prog = 0;
        running = 1'b0;
        done = 1'b0;
        foreach (wp_written[i]) begin
            wp_written[i] = 1'b0;
            wp_x[i] = '0;
            wp_y[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fill the table with extremes and a zero-length segment
        write_reg(epf_pkg::REG_COUNT, 16);
        write_reg(epf_pkg::REG_SPEED, 65535);
        for (int i = 0; i < 16; i++) begin
            push_req(epf_pkg::FUNC_LOAD, i, (i % 2) ? 4095 : 0,
                     (i == 3) ? 0 : ((i % 3) ? 4095 : 0), 0);
        end
        push_req(epf_pkg::FUNC_LOAD, 4, 4095, 0, 1048575);
        push_req(epf_pkg::FUNC_TICK, 0, 0, 0, 1048575);
        push_req(epf_pkg::FUNC_START, 0, 0, 0, 0);
        push_req(epf_pkg::FUNC_TICK, 0, 0, 0, 0);
        push_req(epf_pkg::FUNC_TICK, 0, 0, 0, 1000);
        push_req(epf_pkg::FUNC_START, 0, 0, 0, 0);
        push_req(epf_pkg::FUNC_TICK, 0, 0, 0, 1048575);
        push_req(epf_pkg::FUNC_TICK, 0, 0, 0, 1048575);
        push_req(epf_pkg::FUNC_RESET, 15, 4095, 4095, 1048575);
        drain();

        // random phases over idling modes and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 81; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 81; end
                default: begin src_idle_pct = 35; snk_idle_pct = 35; end
            endcase
            write_reg(epf_pkg::REG_SPEED, speeds[ph]);
            write_reg(epf_pkg::REG_SMOOTH, smooths[ph]);
            write_reg(epf_pkg::REG_COUNT, counts[ph]);
            repeat (175) push_random_req();
            drain();
        end

        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expected_pos.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
